>>> rtl/cpr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpr_pkg: shared types and constants of the codepoint run cleaner
// Payload structs of the input and result channels, special codepoints and
// the whitespace membership test.
// ----------------------------------------------------------------------------
package cpr_pkg;

  localparam int unsigned CpWidth = 21;

  localparam logic [CpWidth-1:0] CpByteOrderMark = 21'h00FEFF;
  localparam logic [CpWidth-1:0] CpSoftHyphen    = 21'h0000AD;
  localparam logic [CpWidth-1:0] CpLigFf         = 21'h00FB00;
  localparam logic [CpWidth-1:0] CpLigFfl        = 21'h00FB04;
  localparam logic [CpWidth-1:0] CpSpace         = 21'h000020;
  localparam logic [CpWidth-1:0] CpLetterF       = 21'h000066;
  localparam logic [CpWidth-1:0] CpLetterI       = 21'h000069;
  localparam logic [CpWidth-1:0] CpLetterL       = 21'h00006C;

  // Low three bits of the ligature codepoints.
  localparam logic [2:0] LigFf  = 3'd0;
  localparam logic [2:0] LigFi  = 3'd1;
  localparam logic [2:0] LigFl  = 3'd2;
  localparam logic [2:0] LigFfi = 3'd3;
  localparam logic [2:0] LigFfl = 3'd4;

  typedef struct packed {
    logic [CpWidth-1:0] codepoint;
    logic               run_start;
    logic               italic;
  } cpr_in_t;

  typedef struct packed {
    logic [CpWidth-1:0] out_codepoint;
    logic               out_italic;
    logic               last_of_item;
  } cpr_out_t;

  typedef enum logic [1:0] {
    ClsDrop  = 2'd0,
    ClsSpace = 2'd1,
    ClsLig   = 2'd2,
    ClsPlain = 2'd3
  } cpr_cls_e;

  // Unicode whitespace as collapsed by the cleaner.
  function automatic logic is_space(input logic [CpWidth-1:0] c);
    logic hit;
    hit = ((c >= 21'h09) && (c <= 21'h0D)) ||
          ((c >= 21'h1C) && (c <= 21'h20)) ||
          ((c >= 21'h2000) && (c <= 21'h200A)) ||
          (c == 21'h85)   || (c == 21'hA0)   || (c == 21'h1680) ||
          (c == 21'h2028) || (c == 21'h2029) || (c == 21'h202F) ||
          (c == 21'h205F) || (c == 21'h3000);
    return hit;
  endfunction

endpackage

>>> rtl/cpr_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpr_stream_if: valid/ready stream channel
// Carries one payload item per handshake; the payload type is a parameter.
// ----------------------------------------------------------------------------
interface cpr_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

>>> rtl/codepoint_run_cleaner.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// codepoint_run_cleaner: codepoint stream cleanup for text runs
// Drops byte-order marks and soft hyphens, expands Latin ligatures and
// collapses whitespace stretches into one ASCII space.
// ----------------------------------------------------------------------------
// Usage:
// The input channel in_i takes one item per handshake: a codepoint, the
// run_start flag of the first codepoint of a run and the italic mark. The
// result channel out_o gives one cleaned codepoint per handshake, with the
// italic mark copied and last_of_item set on the final result of an item.
// An item is accepted into an input register, where it is decoded, and its
// first result is written into the output register, which offers it on out_o.
// A new item is taken in the cycle that the held item retires. A ligature
// holds the input register until it has written one result per letter; a
// dropped codepoint or a whitespace codepoint inside a stretch leaves the
// input register with no result, without waiting on out_o. The input
// register and the output register are separate stages, so a new item is
// taken while a result still waits on out_o.
// When the receiver stalls, the output register holds its result, an item
// with a result to give waits in the input register and holds in_i.ready low.
// Reset (rst_ni low) empties both stages and clears the whitespace flag.
// ----------------------------------------------------------------------------
module codepoint_run_cleaner
  import cpr_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  cpr_stream_if.sink          in_i,
  cpr_stream_if.source        out_o
);

  // Input register stage.
  logic     s1_valid_q;
  cpr_in_t  s1_q;
  // Index of the next result of the item held in the input register.
  logic [1:0] idx_q, idx_d;
  // Inside a whitespace stretch of the current run.
  logic     ws_q, ws_d;

  // Output register stage.
  logic     out_valid_q, out_valid_d;
  cpr_out_t out_q;

  logic               eff_ws;
  cpr_cls_e           cls;
  logic [1:0]         cnt;
  logic [CpWidth-1:0] res_cp;
  logic               res_last;
  logic               out_load;
  logic               emit;
  logic               retire;
  logic               in_accept;

  // A run start clears the stretch before this codepoint is judged.
  assign eff_ws = ws_q & ~s1_q.run_start;

  always_comb begin
    priority if ((s1_q.codepoint == CpByteOrderMark) ||
                 (s1_q.codepoint == CpSoftHyphen)) begin
      cls = ClsDrop;
    end else if (is_space(s1_q.codepoint)) begin
      cls = ClsSpace;
    end else if ((s1_q.codepoint >= CpLigFf) && (s1_q.codepoint <= CpLigFfl)) begin
      cls = ClsLig;
    end else begin
      cls = ClsPlain;
    end
  end

  // Number of results the held item causes.
  always_comb begin
    unique case (cls)
      ClsDrop:  cnt = 2'd0;
      ClsSpace: cnt = eff_ws ? 2'd0 : 2'd1;
      ClsLig:   cnt = ((s1_q.codepoint[2:0] == LigFfi) ||
                       (s1_q.codepoint[2:0] == LigFfl)) ? 2'd3 : 2'd2;
      ClsPlain: cnt = 2'd1;
      default:  cnt = 2'd0;
    endcase
  end

  // Result codepoint at the current index; ligatures spell out their letters.
  always_comb begin
    res_cp = s1_q.codepoint;
    unique case (cls)
      ClsSpace: res_cp = CpSpace;
      ClsLig: begin
        if (idx_q == 2'd0) begin
          res_cp = CpLetterF;
        end else if (idx_q == 2'd1) begin
          unique case (s1_q.codepoint[2:0])
            LigFi:   res_cp = CpLetterI;
            LigFl:   res_cp = CpLetterL;
            default: res_cp = CpLetterF;
          endcase
        end else begin
          res_cp = (s1_q.codepoint[2:0] == LigFfl) ? CpLetterL : CpLetterI;
        end
      end
      default: res_cp = s1_q.codepoint;
    endcase
  end

  assign res_last  = (idx_q == (cnt - 2'd1));
  assign out_load  = ~out_valid_q | out_o.ready;
  assign emit      = s1_valid_q & (cnt != 2'd0) & out_load;
  assign retire    = s1_valid_q & ((cnt == 2'd0) | (emit & res_last));
  assign in_i.ready = ~s1_valid_q | retire;
  assign in_accept = in_i.valid & in_i.ready;

  always_comb begin
    idx_d = idx_q;
    ws_d  = ws_q;
    if (retire) begin
      idx_d = 2'd0;
      // Dropped codepoints keep the stretch; whitespace opens or continues it.
      ws_d  = (cls == ClsDrop) ? eff_ws : (cls == ClsSpace);
    end else if (emit) begin
      idx_d = idx_q + 2'd1;
    end
  end

  assign out_valid_d = emit | (out_valid_q & ~out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      idx_q       <= 2'd0;
      ws_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_accept) begin
        s1_valid_q <= 1'b1;
      end else if (retire) begin
        s1_valid_q <= 1'b0;
      end
      idx_q       <= idx_d;
      ws_q        <= ws_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_q <= in_i.payload;
    end
    if (emit) begin
      out_q.out_codepoint <= res_cp;
      out_q.out_italic    <= s1_q.italic;
      out_q.last_of_item  <= res_last;
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_q;

`ifndef NO_ASSERTIONS
  // A nonzero result index only exists while a ligature is being expanded.
  a_idx_only_lig: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (idx_q != 2'd0) |-> (s1_valid_q && (cls == ClsLig)))
    else $error("result index set outside a ligature expansion");

  // Retiring a whitespace codepoint always leaves the block inside a stretch.
  a_space_sets_ws: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (retire && (cls == ClsSpace)) |=> ws_q)
    else $error("whitespace flag not set after a whitespace codepoint");

  // A dropped codepoint without run start leaves the stretch as it was.
  a_drop_keeps_ws: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (retire && (cls == ClsDrop) && !s1_q.run_start) |=> $stable(ws_q))
    else $error("dropped codepoint changed the whitespace flag");

  // Every emitted space result comes from outside a stretch.
  a_space_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && (cls == ClsSpace)) |-> !eff_ws)
    else $error("space emitted inside a whitespace stretch");

  // A held item that cannot retire blocks the input.
  a_hold_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !retire) |-> !in_i.ready)
    else $error("input accepted over a pending item");
`endif

endmodule
